// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property that must also hold while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/chtr_pkg.sv
// ----------------------------------------------------------------------------
// chtr_pkg
// Function codes, status codes, CSR indices, hash constants and hash step of the
// chained hash table.
package chtr_pkg;

   localparam logic [2:0] FUNC_ADD     = 3'd0;
   localparam logic [2:0] FUNC_DELETE  = 3'd1;
   localparam logic [2:0] FUNC_READ    = 3'd2;
   localparam logic [2:0] FUNC_WRITE   = 3'd3;
   localparam logic [2:0] FUNC_RELEASE = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_BUSY      = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_REL   = 3'd4;

   localparam logic [1:0] CSR_HASH_SELECT = 2'd0;
   localparam logic [1:0] CSR_BUCKET_MASK = 2'd1;
   localparam logic [1:0] CSR_NODE_LIMIT  = 2'd2;

   localparam logic [31:0] JS_SEED = 32'd1315423911;
   localparam logic [31:0] ELF_TOP = 32'hF000_0000;

   // One byte step of either hash.
   function automatic logic [31:0] hash_step(input logic sel, input logic [31:0] h,
                                             input logic [7:0] b);
      logic [31:0] t;
      logic [31:0] x;
      t = '0;
      x = '0;
      if (sel) begin
         t = h ^ ((h << 5) + {24'd0, b} + (h >> 2));
      end else begin
         t = (h << 4) + {24'd0, b};
         x = t & ELF_TOP;
         t = (t ^ (x >> 24)) & ~x;
      end
      return t;
   endfunction

endpackage

// File: sv/chained_hash_table_refcount.sv
// ----------------------------------------------------------------------------
// chained_hash_table_refcount
// Separately chained keyed table with per-node reference counts.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_func/key/key_len/user_data/handle start & !busy
//  result    rsp_status/user_data_out/handle_out rsp_valid, one cycle
//  config    csr_we/csr_index/csr_wdata          csr_we
//
// One item at a time. After accept the hash walks the key bytes, then the
// bucket is read, then chain nodes are visited with one node memory read
// each until a match or the end of the chain. The update writes the node for a
// request; a delete or an add also writes the bucket, and an add behind a
// tail also fixes the old tail's link. A release skips hash and chain and
// does a read-modify-write of its node; an unknown func answers at once.
// The result strobe comes in the cycle busy drops. After reset a clearing pass
// empties the buckets and zeroes node counts; busy stays high meanwhile.
// The receiver cannot stall: the result strobe lasts one cycle.
module chained_hash_table_refcount
   import chtr_pkg::*;
#(
   parameter int POOL_NODES = 256,
   parameter int BUCKETS    = 512,
   parameter int KEY_BYTES  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_func,
   input  logic [63:0]          req_key,
   input  logic [3:0]           req_key_len,
   input  logic signed [63:0]   req_user_data,
   input  logic [7:0]           req_handle,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic signed [63:0]   rsp_user_data_out,
   output logic [7:0]           rsp_handle_out,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [8:0]           csr_wdata
);

`include "assert_macros.svh"

   localparam int NW = $clog2(POOL_NODES + 1);      // node index incl. null
   localparam int HW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
   localparam int CLR_N = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
   localparam int CW = $clog2(CLR_N + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_BRD   = 4'd3;
   localparam logic [3:0] S_BWAIT = 4'd4;
   localparam logic [3:0] S_NRD   = 4'd5;
   localparam logic [3:0] S_NWAIT = 4'd6;
   localparam logic [3:0] S_ACT   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_RELW  = 4'd9;
   localparam logic [3:0] S_RMW   = 4'd10;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  len;
      logic [63:0] data;
      logic [7:0]  refs;
      logic        writer;
      logic [NW-1:0] link;
   } node_type;

   // memories
   node_type          node_mem [POOL_NODES];
   logic [2*NW-1:0]   bkt_mem  [BUCKETS];     // {head, tail}
   logic [HW-1:0]     free_mem [POOL_NODES];

   logic              node_we;
   logic [HW-1:0]     node_waddr, node_raddr;
   node_type          node_wdata, node_rd_ff;
   logic              bkt_we;
   logic [BW-1:0]     bkt_waddr, bkt_raddr;
   logic [2*NW-1:0]   bkt_wdata, bkt_rd_ff;
   logic              free_we;
   logic [HW-1:0]     free_waddr, free_raddr, free_rd_ff;
   logic [HW-1:0]     free_wdata;

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rd_ff <= node_mem[node_raddr];
      if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
      bkt_rd_ff <= bkt_mem[bkt_raddr];
      if (free_we) free_mem[free_waddr] <= free_wdata;
      free_rd_ff <= free_mem[free_raddr];
   end

   // configuration
   logic       hsel_ff;
   logic [8:0] mask_ff, limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         hsel_ff  <= 1'b0;
         mask_ff  <= 9'd511;
         limit_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HASH_SELECT: hsel_ff  <= csr_wdata[0];
            CSR_BUCKET_MASK: mask_ff  <= csr_wdata;
            CSR_NODE_LIMIT:  limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and item registers
   logic [3:0]      state_ff, state_in;
   logic [CW-1:0]   clr_ff, clr_in;
   logic [NW-1:0]   free_cnt_ff, free_cnt_in;
   logic [NW-1:0]   init_ff, init_in;       // lowest stack position ever popped
   logic [NW-1:0]   alloc_ff, alloc_in;
   logic [2:0]      func_ff, func_in;
   logic [63:0]     key_ff, key_in;
   logic [3:0]      len_ff, len_in;
   logic [63:0]     udata_ff, udata_in;
   logic [31:0]     hash_ff, hash_in;
   logic [3:0]      idx_ff, idx_in;
   logic [BW-1:0]   bkt_ff, bkt_in;
   logic [NW-1:0]   cur_ff, cur_in, prev_ff, prev_in;
   logic [NW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]   nlink_ff, nlink_in;
   logic            rv_ff, rv_in;
   logic [2:0]      rst_ff, rst_in;
   logic [63:0]     rd_ff, rd_in;
   logic [7:0]      rh_ff, rh_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         free_cnt_ff <= NW'(POOL_NODES);
         init_ff     <= NW'(POOL_NODES);
         alloc_ff    <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         free_cnt_ff <= free_cnt_in;
         init_ff     <= init_in;
         alloc_ff    <= alloc_in;
         rv_ff       <= rv_in;
      end
      func_ff  <= func_in;  key_ff  <= key_in;   len_ff  <= len_in;
      udata_ff <= udata_in; hash_ff <= hash_in;
      idx_ff   <= idx_in;   bkt_ff  <= bkt_in;   cur_ff  <= cur_in;
      prev_ff  <= prev_in;  head_ff <= head_in;  tail_ff <= tail_in;
      nlink_ff <= nlink_in; rst_ff  <= rst_in;   rd_ff   <= rd_in;
      rh_ff    <= rh_in;
   end

   // key masking and length clamp at accept
   logic [3:0]  len_c;
   logic [63:0] key_c;
   always_comb begin
      len_c = (req_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_key_len;
      key_c = '0;
      for (int i = 0; i < 8; i++)
         if (4'(i) < len_c) key_c[8*i +: 8] = req_key[8*i +: 8];
   end

   logic [31:0] bmask;
   logic        match;
   // The stack is pristine below init: entry i holds POOL_NODES-1-i.
   logic [HW-1:0] pop_idx;
   logic [NW-1:0] pop_pos;

   always_comb begin
      bmask = {23'd0, mask_ff} & 32'(BUCKETS - 1);
      match = (node_rd_ff.len == len_ff) && (node_rd_ff.key == key_ff);
      pop_pos = free_cnt_ff - NW'(1);
      pop_idx = (pop_pos < init_ff) ? HW'(NW'(POOL_NODES - 1) - pop_pos) : free_rd_ff;
   end

   always_comb begin
      state_in = state_ff;   clr_in = clr_ff;  free_cnt_in = free_cnt_ff;
      init_in = init_ff;     alloc_in = alloc_ff;
      func_in = func_ff;     key_in = key_ff;  len_in = len_ff;
      udata_in = udata_ff;   hash_in = hash_ff;
      idx_in = idx_ff;       bkt_in = bkt_ff;  cur_in = cur_ff;
      prev_in = prev_ff;     head_in = head_ff; tail_in = tail_ff;
      nlink_in = nlink_ff;   rv_in = 1'b0;     rst_in = rst_ff;
      rd_in = rd_ff;         rh_in = rh_ff;
      node_we = 1'b0; node_waddr = cur_ff[HW-1:0]; node_wdata = node_rd_ff;
      node_raddr = cur_ff[HW-1:0];
      bkt_we = 1'b0;  bkt_waddr = bkt_ff; bkt_wdata = {head_ff, tail_ff};
      bkt_raddr = bkt_ff;
      free_we = 1'b0; free_waddr = free_cnt_ff[HW-1:0]; free_wdata = cur_ff[HW-1:0];
      free_raddr = pop_pos[HW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            // empty one bucket and zero one node per cycle
            if (clr_ff < CW'(BUCKETS)) begin
               bkt_we = 1'b1;
               bkt_waddr = clr_ff[BW-1:0];
               bkt_wdata = {NIL, NIL};
            end
            if (clr_ff < CW'(POOL_NODES)) begin
               node_we = 1'b1;
               node_waddr = clr_ff[HW-1:0];
               node_wdata = '0;
               node_wdata.link = NIL;
            end
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               func_in = req_func; key_in = key_c; len_in = len_c;
               udata_in = req_user_data;
               hash_in = req_key_len == 4'd0 ? (hsel_ff ? JS_SEED : 32'd0)
                                             : (hsel_ff ? JS_SEED : 32'd0);
               idx_in = '0;
               rst_in = ST_OK; rd_in = '0; rh_in = '0;
               if (req_func == FUNC_RELEASE) begin
                  cur_in = {1'b0, req_handle[HW-1:0]};
                  if (32'(req_handle) >= 32'(POOL_NODES)) begin
                     rst_in = ST_BAD_REL; rv_in = 1'b1;
                  end else state_in = S_RELW;
               end else if (req_func <= FUNC_WRITE) begin
                  state_in = S_HASH;
               end else rv_in = 1'b1;
            end
         end
         S_HASH: begin
            // one key byte per cycle
            if (idx_ff < len_ff) begin
               hash_in = hash_step(hsel_ff, hash_ff, key_ff[8*idx_ff[2:0] +: 8]);
               idx_in = idx_ff + 4'd1;
            end else begin
               bkt_in = BW'(hash_ff & bmask);
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            state_in = S_BWAIT;     // bucket read in flight
         end
         S_BWAIT: begin
            head_in = bkt_rd_ff[2*NW-1:NW];
            tail_in = bkt_rd_ff[NW-1:0];
            prev_in = NIL;
            if (func_ff == FUNC_ADD) begin
               if ({{(9-NW+1){1'b0}}, alloc_ff} >= {1'b0, limit_ff} ||
                   free_cnt_ff == '0) begin
                  rst_in = ST_FULL; rv_in = 1'b1; state_in = S_IDLE;
               end else state_in = S_ACT;    // free top read in flight
            end else begin
               cur_in = bkt_rd_ff[2*NW-1:NW];
               state_in = S_NRD;
            end
         end
         S_NRD: begin
            if (cur_ff == NIL) begin
               rst_in = ST_NOT_FOUND; rv_in = 1'b1; state_in = S_IDLE;
            end else state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (match) state_in = S_ACT;
            else begin
               prev_in = cur_ff;
               cur_in = node_rd_ff.link;
               state_in = S_NRD;
            end
         end
         S_ACT: begin
            if (func_ff == FUNC_ADD) begin
               node_we = 1'b1;
               node_waddr = pop_idx;
               node_wdata = '{key: key_ff, len: len_ff, data: udata_ff,
                              refs: 8'd0, writer: 1'b0, link: NIL};
               cur_in = {1'b0, pop_idx};
               free_cnt_in = free_cnt_ff - NW'(1);
               if (pop_pos < init_ff) init_in = pop_pos;
               alloc_in = alloc_ff + NW'(1);
               tail_in = {1'b0, pop_idx};
               if (tail_ff == NIL) begin
                  head_in = {1'b0, pop_idx};
                  nlink_in = NIL;
               end else nlink_in = tail_ff;      // old tail gets a link fix
               state_in = S_FIN;
               rv_in = (tail_ff == NIL) ? 1'b0 : 1'b0;
            end else if (func_ff == FUNC_DELETE) begin
               if (node_rd_ff.refs != 8'd0) begin
                  rst_in = ST_BUSY; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  rd_in = node_rd_ff.data;
                  if (prev_ff == NIL) head_in = node_rd_ff.link;
                  if (tail_ff == cur_ff) tail_in = prev_ff;
                  nlink_in = node_rd_ff.link;
                  if (free_cnt_ff < NW'(POOL_NODES)) begin
                     free_we = 1'b1;
                     free_cnt_in = free_cnt_ff + NW'(1);
                  end
                  if (alloc_ff != '0) alloc_in = alloc_ff - NW'(1);
                  node_raddr = prev_ff[HW-1:0];
                  state_in = S_FIN;
               end
            end else begin
               if (node_rd_ff.writer || (func_ff == FUNC_READ ? node_rd_ff.refs == 8'hFF
                                                              : node_rd_ff.refs != 8'd0)) begin
                  rst_in = ST_BUSY; rv_in = 1'b1;
               end else begin
                  node_we = 1'b1;
                  node_wdata.refs = (func_ff == FUNC_READ) ? node_rd_ff.refs + 8'd1 : 8'd1;
                  node_wdata.writer = (func_ff == FUNC_WRITE);
                  rd_in = node_rd_ff.data;
                  rh_in = 8'(cur_ff);
                  rv_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            // bucket update; link fix of the previous node for a delete, read of the old tail for an add
            bkt_we = 1'b1;
            node_raddr = nlink_ff[HW-1:0];
            if (func_ff == FUNC_ADD) begin
               if (nlink_ff != NIL) begin
                  state_in = S_RELW; cur_in = nlink_ff;   // reuse read/write path
                  nlink_in = cur_ff;
               end else begin
                  rv_in = 1'b1; state_in = S_IDLE;
               end
            end else begin
               if (prev_ff != NIL) begin
                  node_we = 1'b1;
                  node_waddr = prev_ff[HW-1:0];
                  node_wdata = node_rd_ff;
                  node_wdata.link = nlink_ff;
               end
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_RELW: begin
            // node at cur is being read; next cycle modify
            node_raddr = cur_ff[HW-1:0];
            state_in = S_RMW;
         end
         S_RMW: begin
            // read-modify-write of node cur: release or add link fix
            if (func_ff == FUNC_ADD) begin
               node_we = 1'b1;
               node_wdata.link = nlink_ff;
               rv_in = 1'b1;
            end else if (node_rd_ff.refs == 8'd0) begin
               rst_in = ST_BAD_REL; rv_in = 1'b1;
            end else begin
               node_we = 1'b1;
               node_wdata.refs = node_rd_ff.refs - 8'd1;
               node_wdata.writer = 1'b0;
               rv_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_status        = rst_ff;
   assign rsp_user_data_out = rd_ff;
   assign rsp_handle_out    = rh_ff;

   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")
   `ASSERT_CLK(a_no_start_busy, clock, reset, (start && !busy) |=> !rsp_valid || busy == 1'b0,
      "accept and result overlap")
   `ASSERT_CLK(a_alloc_bound, clock, reset,
      32'(alloc_ff) + 32'(free_cnt_ff) <= 32'(POOL_NODES), "node accounting broken")

endmodule
